### rtl/core/mcts_pkg.sv
// shared types, codes and keyword tables of the token scanner
package mcts_pkg;

   localparam int LEX_MAX_DEF  = 32;
   localparam int TEXT_MAX_DEF = 65536;
   localparam int FIFO_DEPTH   = 4;

   typedef enum logic [4:0] {
      MODE_IDLE, MODE_SLASH, MODE_LCOM, MODE_BCOM, MODE_BSTAR, MODE_ID, MODE_INT,
      MODE_DOT, MODE_FRAC, MODE_EXPE, MODE_EXPS, MODE_EXPD, MODE_Q0, MODE_Q1,
      MODE_QSCAN, MODE_GT, MODE_LT, MODE_EQ, MODE_BANG
   } mode_type;

   localparam logic [5:0] KIND_ID     = 6'd8;
   localparam logic [5:0] KIND_INT    = 6'd9;
   localparam logic [5:0] KIND_EXP    = 6'd10;
   localparam logic [5:0] KIND_CHAR   = 6'd11;
   localparam logic [5:0] KIND_LBRACE = 6'd12;
   localparam logic [5:0] KIND_RBRACE = 6'd13;
   localparam logic [5:0] KIND_LPAREN = 6'd14;
   localparam logic [5:0] KIND_RPAREN = 6'd15;
   localparam logic [5:0] KIND_COMMA  = 6'd16;
   localparam logic [5:0] KIND_SEMI   = 6'd17;
   localparam logic [5:0] KIND_COLON  = 6'd18;
   localparam logic [5:0] KIND_PLUS   = 6'd19;
   localparam logic [5:0] KIND_MINUS  = 6'd20;
   localparam logic [5:0] KIND_STAR   = 6'd21;
   localparam logic [5:0] KIND_SLASH  = 6'd22;
   localparam logic [5:0] KIND_PCT    = 6'd23;
   localparam logic [5:0] KIND_GT     = 6'd24;
   localparam logic [5:0] KIND_GE     = 6'd25;
   localparam logic [5:0] KIND_LT     = 6'd26;
   localparam logic [5:0] KIND_LE     = 6'd27;
   localparam logic [5:0] KIND_ASSIGN = 6'd28;
   localparam logic [5:0] KIND_EQ     = 6'd29;
   localparam logic [5:0] KIND_NE     = 6'd30;
   localparam logic [5:0] KIND_END    = 6'd31;
   localparam logic [5:0] KIND_ERR    = 6'd32;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_OPEN_COMMENT = 3'd1;
   localparam logic [2:0] ERR_LONG_INT     = 3'd2;
   localparam logic [2:0] ERR_BAD_EXP      = 3'd3;
   localparam logic [2:0] ERR_BAD_CHAR     = 3'd4;
   localparam logic [2:0] ERR_UNKNOWN      = 3'd5;

   // keyword text packed first character in the low byte
   localparam logic [55:0] KW_WORD [8] = '{
      56'h64696f76, 56'h746e69, 56'h656c62756f64, 56'h686374697773,
      56'h65736163, 56'h746c7561666564, 56'h6b61657262, 56'h6e69616d
   };
   localparam logic [3:0] KW_LEN [8] = '{4'd4, 4'd3, 4'd6, 4'd6, 4'd4, 4'd7, 4'd5, 4'd4};

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [15:0] start;
      logic [4:0]  len;
      logic [15:0] line;
   } token_type;

endpackage

### rtl/core/mcts_core.sv
// scanner state and the combinational step that turns one character into tokens
module mcts_core #(
   parameter int LEX_MAX  = mcts_pkg::LEX_MAX_DEF,
   parameter int TEXT_MAX = mcts_pkg::TEXT_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 char_code,
   input  logic                       csr_wr_en,
   input  logic [4:0]                 csr_wr_data,
   output logic [1:0]                 push_count,
   output mcts_pkg::token_type [1:0]  tokens
);
   import mcts_pkg::*;

   localparam int KL_W  = $clog2(LEX_MAX);
   localparam int OFF_W = $clog2(TEXT_MAX);
   localparam logic [KL_W-1:0]  KL_TOP  = KL_W'(LEX_MAX - 1);
   localparam logic [OFF_W-1:0] OFF_TOP = OFF_W'(TEXT_MAX - 1);

   logic [4:0]       limit_ff;
   mode_type         mode_ff, mode_in;
   logic [OFF_W-1:0] off_ff, off_in, ts_ff, ts_in;
   logic [15:0]      line_ff, line_in, tl_ff, tl_in;
   logic [KL_W-1:0]  kl_ff, kl_in;
   logic [7:0]       dc_ff, dc_in, q_ff, q_in;
   logic [55:0]      kw_ff, kw_in;
   logic             ovf_ff, ovf_in, halt_ff, halt_in;

   always_comb begin
      logic [4:0] lim;
      logic [1:0] n;
      logic       do_idle;
      logic       is_dig;
      logic       is_let;
      logic [5:0] kind;
      logic [7:0] c;
      mode_type   m;
      logic [OFF_W-1:0] ts;
      logic [15:0] tl;
      logic [KL_W-1:0] kl;
      logic [7:0]  dc;
      logic [7:0]  q;
      logic [55:0] kw;
      logic        ovf;
      logic        halt;
      logic [15:0] ln;
      logic [OFF_W-1:0] off;
      lim = (limit_ff == 5'd0) ? 5'd1 : limit_ff;
      c = char_code;
      m = mode_ff; ts = ts_ff; tl = tl_ff; kl = kl_ff; dc = dc_ff; q = q_ff;
      kw = kw_ff; ovf = ovf_ff; halt = halt_ff; ln = line_ff; off = off_ff;
      n = 2'd0;
      do_idle = 1'b0;
      kind = KIND_ID;
      tokens = '0;
      is_dig = (c >= "0") && (c <= "9");
      is_let = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

      if (!halt) begin
         unique case (m)
            MODE_SLASH: begin
               if (c == "/") m = MODE_LCOM;
               else if (c == "*") begin kl = '0; m = MODE_BCOM; end
               else begin
                  tokens[n[0]] = {KIND_SLASH, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE; do_idle = 1'b1;
               end
            end
            MODE_LCOM: begin
               if (c == "\n") m = MODE_IDLE;
               else if (c == 8'd0) begin m = MODE_IDLE; do_idle = 1'b1; end
            end
            MODE_BCOM, MODE_BSTAR: begin
               if (c == 8'd0 || c == "#") begin
                  tokens[n[0]] = {KIND_ERR, ERR_OPEN_COMMENT, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end else if (c == "/" && m == MODE_BSTAR) m = MODE_IDLE;
               else m = (c == "*") ? MODE_BSTAR : MODE_BCOM;
            end
            MODE_ID: begin
               if (is_let || is_dig) begin
                  if (9'(kl) < 9'd7) kw = kw | (56'(c) << (8 * int'(kl)));
                  if (kl < KL_TOP) kl = kl + 1'b1;
               end else begin
                  kind = KIND_ID;
                  for (int k = 0; k < 8; k++) begin
                     if (kind == KIND_ID && 9'(kl) == 9'(KW_LEN[k]) && kw == KW_WORD[k])
                        kind = 6'(k);
                  end
                  tokens[n[0]] = {kind, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE; do_idle = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_dig) begin
                  if (dc >= 8'(lim)) ovf = 1'b1;
                  if (dc < 8'd255) dc = dc + 8'd1;
                  if (kl < KL_TOP) kl = kl + 1'b1;
               end else if (ovf) begin
                  tokens[n[0]] = {KIND_ERR, ERR_LONG_INT, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end else if (c == ".") begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_FRAC;
               end else if (c == "e" || c == "E") begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_EXPE;
               end else begin
                  tokens[n[0]] = {KIND_INT, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE; do_idle = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_dig) begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_FRAC;
               end else begin
                  tokens[n[0]] = {KIND_ERR, ERR_BAD_EXP, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end
            end
            MODE_FRAC: begin
               if (is_dig) begin
                  if (9'(kl) < 9'(lim) && kl < KL_TOP) kl = kl + 1'b1;
               end else if (c == "e" || c == "E") begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_EXPE;
               end else begin
                  tokens[n[0]] = {KIND_ERR, ERR_BAD_EXP, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end
            end
            MODE_EXPE: begin
               if (c == "+" || c == "-") begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_EXPS;
               end else if (is_dig) begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_EXPD;
               end else begin
                  tokens[n[0]] = {KIND_EXP, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE; do_idle = 1'b1;
               end
            end
            MODE_EXPS: begin
               if (is_dig) begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  m = MODE_EXPD;
               end else begin
                  tokens[n[0]] = {KIND_ERR, ERR_BAD_EXP, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end
            end
            MODE_EXPD: begin
               if (is_dig) begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
               end else begin
                  tokens[n[0]] = {KIND_EXP, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE; do_idle = 1'b1;
               end
            end
            MODE_Q0: begin
               if (c == 8'd0) begin
                  tokens[n[0]] = {KIND_ERR, ERR_BAD_CHAR, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end else begin q = c; m = MODE_Q1; end
            end
            MODE_Q1: begin
               if (c == "'") begin
                  if (q == "\n") begin
                     tokens[n[0]] = {KIND_ERR, ERR_BAD_CHAR, 16'(24'(ts)), 5'(9'(kl)), tl};
                     n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
                  end else begin
                     kl = KL_W'(1);
                     tokens[n[0]] = {KIND_CHAR, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                     n = n + 2'd1; m = MODE_IDLE;
                  end
               end else if (q == "'" || q == "\n" || q == "#") begin
                  tokens[n[0]] = {KIND_ERR, ERR_BAD_CHAR, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end else begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  if (c == "\n" || c == 8'd0 || c == "#") begin
                     tokens[n[0]] = {KIND_ERR, ERR_BAD_CHAR, 16'(24'(ts)), 5'(9'(kl)), tl};
                     n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
                  end else begin
                     if (kl < KL_TOP) kl = kl + 1'b1;
                     m = MODE_QSCAN;
                  end
               end
            end
            MODE_QSCAN: begin
               if (c == "'" || c == "\n" || c == 8'd0 || c == "#") begin
                  tokens[n[0]] = {KIND_ERR, ERR_BAD_CHAR, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end else if (kl < KL_TOP) kl = kl + 1'b1;
            end
            MODE_GT, MODE_LT, MODE_EQ: begin
               if (c == "=") begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  kind = (m == MODE_GT) ? KIND_GE : (m == MODE_LT) ? KIND_LE : KIND_EQ;
                  tokens[n[0]] = {kind, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE;
               end else begin
                  kind = (m == MODE_GT) ? KIND_GT : (m == MODE_LT) ? KIND_LT : KIND_ASSIGN;
                  tokens[n[0]] = {kind, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE; do_idle = 1'b1;
               end
            end
            MODE_BANG: begin
               if (c == "=") begin
                  if (kl < KL_TOP) kl = kl + 1'b1;
                  tokens[n[0]] = {KIND_NE, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; m = MODE_IDLE;
               end else begin
                  tokens[n[0]] = {KIND_ERR, ERR_UNKNOWN, 16'(24'(ts)), 5'(9'(kl)), tl};
                  n = n + 2'd1; halt = 1'b1; m = MODE_IDLE;
               end
            end
            default: do_idle = 1'b1;
         endcase

         // the byte that closed a token is scanned again as a fresh start
         if (do_idle && !(c == " " || c == "\n" || c == "\t")) begin
            ts = off; tl = ln; kl = '0; m = MODE_IDLE;
            if (c == 8'd0) begin
               kl = KL_W'(1);
               tokens[n[0]] = {KIND_END, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
               n = n + 2'd1;
            end else if (c == "'") m = MODE_Q0;
            else begin
               kl = KL_W'(1);
               kind = KIND_ERR;
               if (is_dig) begin dc = 8'd1; ovf = 1'b0; m = MODE_INT; end
               else if (is_let) begin kw = 56'(c); m = MODE_ID; end
               else begin
                  unique case (c)
                     ".": m = MODE_DOT;
                     "/": m = MODE_SLASH;
                     ">": m = MODE_GT;
                     "<": m = MODE_LT;
                     "=": m = MODE_EQ;
                     "!": m = MODE_BANG;
                     "{": kind = KIND_LBRACE;
                     "}": kind = KIND_RBRACE;
                     "(": kind = KIND_LPAREN;
                     ")": kind = KIND_RPAREN;
                     ",": kind = KIND_COMMA;
                     ";": kind = KIND_SEMI;
                     ":": kind = KIND_COLON;
                     "+": kind = KIND_PLUS;
                     "-": kind = KIND_MINUS;
                     "*": kind = KIND_STAR;
                     "%": kind = KIND_PCT;
                     default: begin
                        kind = KIND_ERR;
                        tokens[n[0]] = {KIND_ERR, ERR_UNKNOWN, 16'(24'(ts)), 5'(9'(kl)), tl};
                        n = n + 2'd1; halt = 1'b1;
                     end
                  endcase
                  if (kind != KIND_ERR) begin
                     tokens[n[0]] = {kind, ERR_NONE, 16'(24'(ts)), 5'(9'(kl)), tl};
                     n = n + 2'd1;
                  end
               end
            end
         end
      end

      if (c == "\n" && ln < 16'hffff) ln = ln + 16'd1;
      off = (off == OFF_TOP) ? '0 : off + 1'b1;
      if (c == 8'd0) begin
         off = '0; ln = 16'd1; m = MODE_IDLE; halt = 1'b0;
      end

      mode_in = m; ts_in = ts; tl_in = tl; kl_in = kl; dc_in = dc; q_in = q;
      kw_in = kw; ovf_in = ovf; halt_in = halt; line_in = ln; off_in = off;
      push_count = step ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 5'd10;
         mode_ff  <= MODE_IDLE;
         off_ff   <= '0;
         line_ff  <= 16'd1;
         ts_ff    <= '0;
         tl_ff    <= 16'd1;
         kl_ff    <= '0;
         dc_ff    <= 8'd0;
         q_ff     <= 8'd0;
         kw_ff    <= '0;
         ovf_ff   <= 1'b0;
         halt_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (step) begin
            mode_ff <= mode_in;
            off_ff  <= off_in;
            line_ff <= line_in;
            ts_ff   <= ts_in;
            tl_ff   <= tl_in;
            kl_ff   <= kl_in;
            dc_ff   <= dc_in;
            q_ff    <= q_in;
            kw_ff   <= kw_in;
            ovf_ff  <= ovf_in;
            halt_ff <= halt_in;
         end
      end
   end

endmodule

### rtl/core/mcts_fifo.sv
// four-entry token queue taking up to two words per cycle
module mcts_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                push_count,
   input  mcts_pkg::token_type [1:0] push_data,
   input  logic                      pop,
   output mcts_pkg::token_type       head,
   output logic [2:0]                level
);
   import mcts_pkg::*;

   token_type  entry_ff [FIFO_DEPTH];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      wp_in    = wp_ff + push_count;
      rp_in    = rp_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) entry_ff[wp_ff] <= push_data[0];
      if (push_count == 2'd2) entry_ff[wp_ff + 2'd1] <= push_data[1];
   end

   assign head  = entry_ff[rp_ff];
   assign level = count_ff;

endmodule

### rtl/core/mini_c_token_scanner.sv
// token scanner top level: one character per cycle in, tokens out through a queue
// a token is written into the queue with the character that completes it, and offered once it reaches the head
// throughput: one character per cycle; set by the combinational scan step and
// the four-word token queue, which holds input while it has fewer than two free slots
// reset: synchronous; mode idle, offset 0, line 1, digit limit 10, queue empty
module mini_c_token_scanner #(
   parameter int LEX_MAX  = mcts_pkg::LEX_MAX_DEF,
   parameter int TEXT_MAX = mcts_pkg::TEXT_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_start_offset,
   output logic [4:0]  rsp_lexeme_length,
   output logic [15:0] rsp_line_number,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import mcts_pkg::*;

   logic            step;
   logic [1:0]      push_count;
   token_type [1:0] tokens;
   token_type       head;
   logic [2:0]      level;

   assign req_ready = (level <= 3'd2);
   assign step      = req_valid && req_ready;
   assign rsp_valid = (level != 3'd0);

   mcts_core #(.LEX_MAX(LEX_MAX), .TEXT_MAX(TEXT_MAX)) u_core (
      .clock(clock), .reset(reset), .step(step), .char_code(req_char_code),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .push_count(push_count), .tokens(tokens)
   );

   mcts_fifo u_fifo (
      .clock(clock), .reset(reset), .push_count(push_count), .push_data(tokens),
      .pop(rsp_valid && rsp_ready), .head(head), .level(level)
   );

   assign rsp_token_kind    = head.kind;
   assign rsp_error_code    = head.err;
   assign rsp_start_offset  = head.start;
   assign rsp_lexeme_length = head.len;
   assign rsp_line_number   = head.line;

`ifndef SYNTH
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= 3'd4) else $error("token queue overfilled");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_ERR |-> rsp_error_code != ERR_NONE)
      else $error("error token without code");
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_ERR |-> rsp_error_code == ERR_NONE)
      else $error("code on a good token");
   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != 16'd0) else $error("line number zero");
`endif

endmodule

### tb/testbench.sv
// token scanner testbench: directed table and random source text checked against a predictor
`timescale 1ns / 100ps

module testbench;
   import mcts_pkg::*;

   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam int RANDOM_ITEMS     = 1200;
   localparam int HOLD_CYCLES      = 80;

   typedef struct {
      logic [7:0] ch;
      bit         typed;
      token_type  tok;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_token_kind;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_start_offset;
   logic [4:0]  rsp_lexeme_length;
   logic [15:0] rsp_line_number;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;

   mini_c_token_scanner u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_error_code    (rsp_error_code),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_line_number   (rsp_line_number),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // scanner state mirrored by the predictor
   mode_type    scan_mode;
   logic [15:0] char_offset, line_count, tok_start, tok_line;
   int          kept_len, digit_count;
   logic [7:0]  held_char;
   logic [55:0] kw_window;
   bit          digit_overflow, halted;
   logic [4:0]  digit_limit;

   token_type    pending_tokens[$];
   logic [7:0]   char_stream[$];
   stim_row_type directed[$];
   string       kw_names[8] = '{"void", "int", "double", "switch", "case", "default",
                                "break", "main"};
   int          fail_count;
   int          rx_count;
   bit          quiet_tx, quiet_rx;

   function automatic void emit_token(logic [5:0] kind, logic [2:0] err);
      token_type t;
      t.kind  = kind;
      t.err   = err;
      t.start = tok_start;
      t.len   = kept_len[4:0];
      t.line  = tok_line;
      pending_tokens.push_back(t);
   endfunction

   function automatic void keep_char();
      if (kept_len < LEX_MAX_DEF - 1) kept_len++;
   endfunction

   function automatic void close_token(logic [5:0] kind);
      emit_token(kind, ERR_NONE);
      scan_mode = MODE_IDLE;
   endfunction

   function automatic void raise_error(logic [2:0] code);
      emit_token(KIND_ERR, code);
      halted    = 1;
      scan_mode = MODE_IDLE;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [5:0] classify_word();
      logic [55:0] w;
      for (int k = 0; k < 8; k++) begin
         w = '0;
         for (int j = 0; j < kw_names[k].len(); j++) w |= 56'(kw_names[k][j]) << (8 * j);
         if (kw_names[k].len() == kept_len && w == kw_window) return 6'(k);
      end
      return KIND_ID;
   endfunction

   function automatic void scan_fresh(logic [7:0] c);
      if (c == " " || c == CH_NL || c == CH_TAB) return;
      tok_start = char_offset;
      tok_line  = line_count;
      kept_len  = 0;
      if (c == 8'h00) begin
         kept_len = 1;
         close_token(KIND_END);
         return;
      end
      if (c == CH_QUOTE) begin
         scan_mode = MODE_Q0;
         return;
      end
      keep_char();
      if (is_digit(c)) begin
         digit_count    = 1;
         digit_overflow = 0;
         scan_mode      = MODE_INT;
      end else if (is_letter(c)) begin
         kw_window = 56'(c);
         scan_mode = MODE_ID;
      end else begin
         case (c)
            ".": scan_mode = MODE_DOT;
            "/": scan_mode = MODE_SLASH;
            ">": scan_mode = MODE_GT;
            "<": scan_mode = MODE_LT;
            "=": scan_mode = MODE_EQ;
            "!": scan_mode = MODE_BANG;
            "{": close_token(KIND_LBRACE);
            "}": close_token(KIND_RBRACE);
            "(": close_token(KIND_LPAREN);
            ")": close_token(KIND_RPAREN);
            ",": close_token(KIND_COMMA);
            ";": close_token(KIND_SEMI);
            ":": close_token(KIND_COLON);
            "+": close_token(KIND_PLUS);
            "-": close_token(KIND_MINUS);
            "*": close_token(KIND_STAR);
            "%": close_token(KIND_PCT);
            default: raise_error(ERR_UNKNOWN);
         endcase
      end
   endfunction

   function automatic void scan_pair(logic [7:0] c, logic [5:0] one, logic [5:0] two);
      if (c == "=") begin
         keep_char();
         close_token(two);
      end else begin
         close_token(one);
         scan_fresh(c);
      end
   endfunction

   function automatic void scan_char(logic [7:0] c);
      int lim;
      lim = (digit_limit == 0) ? 1 : int'(digit_limit);
      if (!halted) begin
         case (scan_mode)
            MODE_IDLE: scan_fresh(c);
            MODE_SLASH: begin
               if (c == "/") scan_mode = MODE_LCOM;
               else if (c == "*") begin
                  kept_len  = 0;
                  scan_mode = MODE_BCOM;
               end else begin
                  close_token(KIND_SLASH);
                  scan_fresh(c);
               end
            end
            MODE_LCOM: begin
               if (c == CH_NL) scan_mode = MODE_IDLE;
               else if (c == 8'h00) begin
                  scan_mode = MODE_IDLE;
                  scan_fresh(c);
               end
            end
            MODE_BCOM, MODE_BSTAR: begin
               if (c == 8'h00 || c == "#") raise_error(ERR_OPEN_COMMENT);
               else if (c == "/" && scan_mode == MODE_BSTAR) scan_mode = MODE_IDLE;
               else scan_mode = (c == "*") ? MODE_BSTAR : MODE_BCOM;
            end
            MODE_ID: begin
               if (is_letter(c) || is_digit(c)) begin
                  if (kept_len < 7) kw_window |= 56'(c) << (8 * kept_len);
                  keep_char();
               end else begin
                  close_token(classify_word());
                  scan_fresh(c);
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  if (digit_count >= lim) digit_overflow = 1;
                  if (digit_count < 255) digit_count++;
                  keep_char();
               end else if (digit_overflow) raise_error(ERR_LONG_INT);
               else if (c == ".") begin
                  keep_char();
                  scan_mode = MODE_FRAC;
               end else if (c == "e" || c == "E") begin
                  keep_char();
                  scan_mode = MODE_EXPE;
               end else begin
                  close_token(KIND_INT);
                  scan_fresh(c);
               end
            end
            MODE_DOT: begin
               if (is_digit(c)) begin
                  keep_char();
                  scan_mode = MODE_FRAC;
               end else raise_error(ERR_BAD_EXP);
            end
            MODE_FRAC: begin
               // fraction digits are kept only while the lexeme length is below the digit limit
               if (is_digit(c)) begin
                  if (kept_len < lim) keep_char();
               end else if (c == "e" || c == "E") begin
                  keep_char();
                  scan_mode = MODE_EXPE;
               end else raise_error(ERR_BAD_EXP);
            end
            MODE_EXPE: begin
               if (c == "+" || c == "-") begin
                  keep_char();
                  scan_mode = MODE_EXPS;
               end else if (is_digit(c)) begin
                  keep_char();
                  scan_mode = MODE_EXPD;
               end else begin
                  close_token(KIND_EXP);
                  scan_fresh(c);
               end
            end
            MODE_EXPS: begin
               if (is_digit(c)) begin
                  keep_char();
                  scan_mode = MODE_EXPD;
               end else raise_error(ERR_BAD_EXP);
            end
            MODE_EXPD: begin
               if (is_digit(c)) keep_char();
               else begin
                  close_token(KIND_EXP);
                  scan_fresh(c);
               end
            end
            MODE_Q0: begin
               if (c == 8'h00) raise_error(ERR_BAD_CHAR);
               else begin
                  held_char = c;
                  scan_mode = MODE_Q1;
               end
            end
            MODE_Q1: begin
               if (c == CH_QUOTE) begin
                  if (held_char == CH_NL) raise_error(ERR_BAD_CHAR);
                  else begin
                     kept_len = 1;
                     close_token(KIND_CHAR);
                  end
               end else if (held_char == CH_QUOTE || held_char == CH_NL ||
                            held_char == "#") begin
                  raise_error(ERR_BAD_CHAR);
               end else begin
                  keep_char();
                  if (c == CH_NL || c == 8'h00 || c == "#") raise_error(ERR_BAD_CHAR);
                  else begin
                     keep_char();
                     scan_mode = MODE_QSCAN;
                  end
               end
            end
            MODE_QSCAN: begin
               if (c == CH_QUOTE || c == CH_NL || c == 8'h00 || c == "#")
                  raise_error(ERR_BAD_CHAR);
               else keep_char();
            end
            MODE_GT: scan_pair(c, KIND_GT, KIND_GE);
            MODE_LT: scan_pair(c, KIND_LT, KIND_LE);
            MODE_EQ: scan_pair(c, KIND_ASSIGN, KIND_EQ);
            MODE_BANG: begin
               if (c == "=") begin
                  keep_char();
                  close_token(KIND_NE);
               end else raise_error(ERR_UNKNOWN);
            end
            default: scan_mode = MODE_IDLE;
         endcase
      end
      if (c == CH_NL && line_count != 16'hffff) line_count++;
      char_offset++;
      if (c == 8'h00) begin
         char_offset = '0;
         line_count  = 16'd1;
         scan_mode   = MODE_IDLE;
         halted      = 0;
      end
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_str(string s);
      foreach (s[i]) char_stream.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic void add_digits(int n);
      repeat (n) char_stream.push_back(rand_digit());
   endfunction

   // one source text of random fragments, ended by a zero byte
   function automatic void make_text();
      int    r, n;
      string ops;
      ops = "{}(),;:+-*/%><=!";
      repeat ($urandom_range(3, 30)) begin
         r = $urandom_range(0, 99);
         if (r < 14) add_str(kw_names[$urandom_range(0, 7)]);
         else if (r < 28) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            char_stream.push_back(rand_letter());
            repeat (n - 1)
               char_stream.push_back($urandom_range(0, 2) ? rand_letter() : rand_digit());
            // identifiers that end in keyword text, as near misses
            if ($urandom_range(0, 3) == 0) add_str(kw_names[$urandom_range(0, 7)]);
         end else if (r < 42) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 35) :
                $urandom_range(1, int'(digit_limit) + 1);
            add_digits(n);
         end else if (r < 50) begin
            case ($urandom_range(0, 5))
               0: add_digits($urandom_range(1, 4));
               1: begin
                  add_digits($urandom_range(1, 3));
                  char_stream.push_back(".");
                  add_digits($urandom_range(0, 36));
               end
               default: begin
                  char_stream.push_back(".");
                  add_digits($urandom_range(1, 5));
               end
            endcase
            if ($urandom_range(0, 7) != 0) begin
               char_stream.push_back($urandom_range(0, 1) ? "e" : "E");
               if ($urandom_range(0, 1)) char_stream.push_back($urandom_range(0, 1) ? "+" : "-");
               add_digits($urandom_range(0, 3));
            end
         end else if (r < 57) begin
            char_stream.push_back(CH_QUOTE);
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(0, 4)) char_stream.push_back(8'($urandom_range(1, 255)));
            end else char_stream.push_back(8'($urandom_range(32, 126)));
            char_stream.push_back(CH_QUOTE);
         end else if (r < 76) begin
            n = $urandom_range(0, ops.len() - 1);
            char_stream.push_back(ops[n]);
            if ($urandom_range(0, 2) == 0) char_stream.push_back("=");
         end else if (r < 82) begin
            if ($urandom_range(0, 1)) begin
               add_str("//");
               repeat ($urandom_range(0, 6)) char_stream.push_back(rand_letter());
               char_stream.push_back(CH_NL);
            end else begin
               add_str("/*");
               repeat ($urandom_range(0, 6))
                  char_stream.push_back($urandom_range(0, 2) ? rand_letter() : 8'h2a);
               if ($urandom_range(0, 9) == 0) char_stream.push_back("#");
               add_str("*/");
            end
         end else if (r < 96) begin
            case ($urandom_range(0, 2))
               0: char_stream.push_back(" ");
               1: char_stream.push_back(CH_NL);
               default: char_stream.push_back(CH_TAB);
            endcase
         end else char_stream.push_back(8'($urandom_range(1, 255)));
         if ($urandom_range(0, 9) < 7) char_stream.push_back($urandom_range(0, 3) ? 8'h20 : CH_NL);
      end
      char_stream.push_back(8'h00);
   endfunction

   task automatic send_char(logic [7:0] c, bit typed, token_type t);
      int gap, n;
      gap = pick_gap(quiet_tx);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1;
      req_char_code = c;
      do @(posedge clock); while (!req_ready);
      n = pending_tokens.size();
      scan_char(c);
      if (typed) begin
         while (pending_tokens.size() > n) void'(pending_tokens.pop_back());
         pending_tokens.push_back(t);
      end
   endtask

   task automatic write_limit(logic [4:0] v);
      @(negedge clock);
      req_valid = 0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en   = 0;
      digit_limit = v;
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rx_count++;
         if (pending_tokens.size() == 0) begin
            $error("unexpected token kind %0d at offset %0d", rsp_token_kind, rsp_start_offset);
            fail_count++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind: expected %0d, got %0d", want.kind, rsp_token_kind);
               fail_count++;
            end
            if (rsp_error_code !== want.err) begin
               $error("error_code: expected %0d, got %0d", want.err, rsp_error_code);
               fail_count++;
            end
            if (rsp_start_offset !== want.start) begin
               $error("start_offset: expected %0d, got %0d", want.start, rsp_start_offset);
               fail_count++;
            end
            if (rsp_lexeme_length !== want.len) begin
               $error("lexeme_length: expected %0d, got %0d", want.len, rsp_lexeme_length);
               fail_count++;
            end
            if (rsp_line_number !== want.line) begin
               $error("line_number: expected %0d, got %0d", want.line, rsp_line_number);
               fail_count++;
            end
         end
      end
   end

   // result side: random stalls, one long hold-off so the token queue fills
   initial begin
      bit held;
      int stall;
      held      = 0;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held && rx_count >= 150) begin
            held      = 1;
            rsp_ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 49) == 0) quiet_rx = !quiet_rx;
         stall = pick_gap(quiet_rx);
         if (stall > 0) begin
            rsp_ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1;
      end
   end

   initial begin
      token_type   none;
      logic [4:0]  limits[5];
      string       dtext;
      int          sent;
      limits        = '{5'd1, 5'd31, 5'd0, 5'd2, 5'd10};
      none          = '0;
      fail_count    = 0;
      rx_count      = 0;
      quiet_tx      = 0;
      quiet_rx      = 0;
      reset         = 1;
      req_valid     = 0;
      req_char_code = '0;
      csr_wr_en     = 0;
      csr_wr_data   = '0;
      scan_mode      = MODE_IDLE;
      char_offset    = '0;
      line_count     = 16'd1;
      tok_start      = '0;
      tok_line       = 16'd1;
      kept_len       = 0;
      digit_count    = 0;
      held_char      = '0;
      kw_window      = '0;
      digit_overflow = 0;
      halted         = 0;
      digit_limit    = 5'd10;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // end of text straight after reset, unknown symbol, ignored input after error
      directed = '{
         '{8'h00, 1'b1, '{KIND_END, ERR_NONE, 16'd0, 5'd1, 16'd1}},
         '{"#", 1'b1, '{KIND_ERR, ERR_UNKNOWN, 16'd0, 5'd1, 16'd1}},
         '{"a", 1'b0, none},
         '{8'h00, 1'b0, none},
         '{"{", 1'b1, '{KIND_LBRACE, ERR_NONE, 16'd0, 5'd1, 16'd1}}
      };
      dtext = "int x=12;\n/*c*/'q'>=!=<= ==0.5e+3 9.e//k\n";
      foreach (dtext[i]) directed.push_back('{dtext[i], 1'b0, none});
      directed.push_back('{"'", 1'b0, none});
      directed.push_back('{"a", 1'b0, none});
      directed.push_back('{"b", 1'b0, none});
      directed.push_back('{"'", 1'b0, none});
      directed.push_back('{8'h00, 1'b0, none});
      foreach (directed[i]) send_char(directed[i].ch, directed[i].typed, directed[i].tok);

      sent = 0;
      for (int ph = 0; ph <= 5; ph++) begin
         if (ph > 0) write_limit((ph == 5) ? 5'($urandom_range(3, 30)) : limits[ph - 1]);
         while (sent < (ph + 1) * RANDOM_ITEMS / 6) begin
            quiet_tx = ($urandom_range(0, 3) == 0);
            make_text();
            while (char_stream.size() != 0) begin
               send_char(char_stream.pop_front(), 1'b0, none);
               sent++;
            end
         end
      end

      @(negedge clock);
      req_valid = 0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

### mini_c_token_scanner.f
rtl/core/mcts_pkg.sv
rtl/core/mcts_core.sv
rtl/core/mcts_fifo.sv
rtl/core/mini_c_token_scanner.sv
tb/testbench.sv
